FILE: design/mbr_pkg.sv
// ----------------------------------------------------------------------------
// mbr_pkg
// Shared types, constants and helpers for the MSB-first bit reader.
// ----------------------------------------------------------------------------
package mbr_pkg;

  localparam int WinW   = 64;
  localparam int WordW  = 32;
  localparam int HeldW  = 7;
  localparam int CountW = 6;

  typedef enum logic [2:0] {
    OP_SUPPLY  = 3'd0,
    OP_READ    = 3'd1,
    OP_UNARY   = 3'd2,
    OP_ALIGN   = 3'd3,
    OP_RESTART = 3'd4,
    OP_NOP     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NEED_DATA = 2'd1,
    ST_REFUSED   = 2'd2
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [CountW-1:0]  count;
    logic [WordW-1:0]   word;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0]   value;
    status_e            status;
    logic [HeldW-1:0]   held;
    logic [WordW-1:0]   consumed;
    logic               done;
  } result_t;

  // Count of leading ones, 0..64, by six halving steps.
  function automatic logic [HeldW-1:0] lead_ones(input logic [WinW-1:0] w);
    logic [WinW-1:0]  x;
    logic [HeldW-1:0] n;
    x = ~w;
    n = '0;
    if (x == '0) begin
      n = 7'd64;
    end else begin
      if (x[63:32] == '0) begin n = n + 7'd32; x = x << 32; end
      if (x[63:48] == '0) begin n = n + 7'd16; x = x << 16; end
      if (x[63:56] == '0) begin n = n + 7'd8;  x = x << 8;  end
      if (x[63:60] == '0) begin n = n + 7'd4;  x = x << 4;  end
      if (x[63:62] == '0) begin n = n + 7'd2;  x = x << 2;  end
      if (x[63] == 1'b0)  begin n = n + 7'd1;               end
    end
    return n;
  endfunction

endpackage

FILE: design/mbr_front.sv
// ----------------------------------------------------------------------------
// mbr_front
// Input side: takes words from the input channel, decodes the function code
// and clamps the read length before the word enters the queue.
// ----------------------------------------------------------------------------
module mbr_front import mbr_pkg::*; #(
  parameter int MAX_READ_BITS = 32
) (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        func_i,
  input  logic [CountW-1:0] bit_count_i,
  input  logic [WordW-1:0]  source_word_i,
  input  logic              full_i,
  output logic              push_o,
  output item_t             item_o
);

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_READ_BITS);

  op_e op;

  always_comb begin
    unique case (func_i)
      3'd0:    op = OP_SUPPLY;
      3'd1:    op = OP_READ;
      3'd2:    op = OP_UNARY;
      3'd3:    op = OP_ALIGN;
      3'd4:    op = OP_RESTART;
      default: op = OP_NOP;
    endcase
  end

  assign in_stall_o   = full_i;
  assign push_o       = in_valid_i & ~full_i;
  assign item_o.op    = op;
  assign item_o.count = (bit_count_i > MaxCount) ? MaxCount : bit_count_i;
  assign item_o.word  = source_word_i;

endmodule

FILE: design/mbr_queue.sv
// ----------------------------------------------------------------------------
// mbr_queue
// Two-entry queue between the decode side and the execute side.
// ----------------------------------------------------------------------------
module mbr_queue import mbr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: design/mbr_back.sv
// ----------------------------------------------------------------------------
// mbr_back
// Execute side: holds the bit window and counters, carries out one queued
// word per cycle while the output is not stalled and registers its result for the output channel.
// ----------------------------------------------------------------------------
module mbr_back import mbr_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [LENGTH_BITS-1:0] cfg_wdata_i,
  input  item_t                  item_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output result_t                res_o
);

  localparam int UsedW = (LENGTH_BITS > WordW) ? LENGTH_BITS : WordW + 1;

  logic [LENGTH_BITS-1:0] length_q;
  logic [WinW-1:0]        win_q, win_d;
  logic [HeldW-1:0]       vb_q, vb_d;
  logic [LENGTH_BITS-1:0] fetched_q, fetched_d;
  logic [WordW-1:0]       unary_q, unary_d;
  logic                   out_valid_q;
  result_t                res_q, res_d;

  function automatic logic [WinW-1:0] drop_win(input logic [WinW-1:0] w,
                                               input logic [HeldW-1:0] k);
    return (k >= 7'd64) ? '0 : (w << k);
  endfunction

  function automatic logic [HeldW-1:0] drop_vb(input logic [HeldW-1:0] v,
                                               input logic [HeldW-1:0] k);
    return (k >= v) ? '0 : (v - k);
  endfunction

  assign pop_o       = ~empty_i & (~out_valid_q | ~out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    logic                   used_up;
    logic [LENGTH_BITS-1:0] rem;
    logic [2:0]             nbytes;
    logic [WordW-1:0]       mword;
    logic [HeldW-1:0]       ones;
    logic [WordW:0]         usum;
    logic [WordW-1:0]       usat;
    logic [WordW-1:0]       value;
    status_e                status;
    logic [LENGTH_BITS-1:0] held;
    logic [UsedW-1:0]       used;

    win_d     = win_q;
    vb_d      = vb_q;
    fetched_d = fetched_q;
    unary_d   = unary_q;
    value     = '0;
    status    = ST_DONE;

    used_up = (fetched_q >= length_q);
    rem     = length_q - fetched_q;
    nbytes  = (rem >= LENGTH_BITS'(4)) ? 3'd4 : rem[2:0];
    mword   = item_i.word & ~(32'hFFFF_FFFF >> {nbytes, 3'b000});
    ones    = lead_ones(win_q);
    if (ones > vb_q) begin
      ones = vb_q;
    end
    usum = {1'b0, unary_q} + {26'b0, ones};
    usat = usum[WordW] ? '1 : usum[WordW-1:0];

    case (item_i.op)
      OP_SUPPLY: begin
        if (vb_q > 7'd32 || used_up) begin
          status = ST_REFUSED;
        end else begin
          win_d     = win_q | ({mword, 32'b0} >> vb_q);
          vb_d      = vb_q + {1'b0, nbytes, 3'b000};
          fetched_d = fetched_q + LENGTH_BITS'(nbytes);
        end
      end
      OP_READ: begin
        if (item_i.count != '0) begin
          if ({1'b0, item_i.count} <= vb_q) begin
            value = win_q[63:32] >> (6'd32 - item_i.count);
            win_d = drop_win(win_q, {1'b0, item_i.count});
            vb_d  = drop_vb(vb_q, {1'b0, item_i.count});
          end else if (used_up) begin
            value = win_q[63:32] >> (6'd32 - item_i.count);
            win_d = '0;
            vb_d  = '0;
          end else begin
            status = ST_NEED_DATA;
          end
        end
      end
      OP_UNARY: begin
        if (ones < vb_q) begin
          // run ends inside the window: drop the ones and the stop bit
          value   = usat;
          unary_d = '0;
          win_d   = drop_win(win_q, ones + 7'd1);
          vb_d    = drop_vb(vb_q, ones + 7'd1);
        end else begin
          win_d = '0;
          vb_d  = '0;
          if (used_up) begin
            value   = usat;
            unary_d = '0;
          end else begin
            unary_d = usat;
            status  = ST_NEED_DATA;
          end
        end
      end
      OP_ALIGN: begin
        win_d = drop_win(win_q, {4'b0, vb_q[2:0]});
        vb_d  = drop_vb(vb_q, {4'b0, vb_q[2:0]});
      end
      OP_RESTART: begin
        win_d     = '0;
        vb_d      = '0;
        fetched_d = '0;
        unary_d   = '0;
      end
      default: begin
      end
    endcase

    held = LENGTH_BITS'(vb_d[HeldW-1:3]);
    used = (fetched_d >= held) ? UsedW'(fetched_d - held) : '0;

    res_d.value    = value;
    res_d.status   = status;
    res_d.held     = vb_d;
    res_d.consumed = (|used[UsedW-1:WordW]) ? '1 : used[WordW-1:0];
    res_d.done     = (fetched_d >= length_q);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q    <= '0;
      win_q       <= '0;
      vb_q        <= '0;
      fetched_q   <= '0;
      unary_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        length_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        win_q       <= win_d;
        vb_q        <= vb_d;
        fetched_q   <= fetched_d;
        unary_q     <= unary_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: design/msb_first_bit_reader.sv
// ----------------------------------------------------------------------------
// msb_first_bit_reader
// A result is registered as its word is popped from the queue.
// Throughput: one word per cycle while the output channel is not stalled.
// Reset: window, counters, stream length and queue clear at once; no sweep.
// ----------------------------------------------------------------------------
module msb_first_bit_reader import mbr_pkg::*; #(
  parameter int MAX_READ_BITS = 32,
  parameter int LENGTH_BITS   = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [LENGTH_BITS-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [2:0]             func_i,
  input  logic [CountW-1:0]      bit_count_i,
  input  logic [WordW-1:0]       source_word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [WordW-1:0]       value_o,
  output logic [1:0]             status_o,
  output logic [HeldW-1:0]       bits_held_o,
  output logic [WordW-1:0]       bytes_consumed_o,
  output logic                   source_done_o
);

  logic    push, full, pop, empty;
  item_t   in_item, q_item;
  result_t res;

  assign cfg_ready_o = 1'b1;

  mbr_front #(
    .MAX_READ_BITS(MAX_READ_BITS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .bit_count_i  (bit_count_i),
    .source_word_i(source_word_i),
    .full_i       (full),
    .push_o       (push),
    .item_o       (in_item)
  );

  mbr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (in_item),
    .full_o (full),
    .pop_i  (pop),
    .item_o (q_item),
    .empty_o(empty)
  );

  mbr_back #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i & cfg_ready_o),
    .cfg_wdata_i(cfg_wdata_i),
    .item_i     (q_item),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign value_o          = res.value;
  assign status_o         = res.status;
  assign bits_held_o      = res.held;
  assign bytes_consumed_o = res.consumed;
  assign source_done_o    = res.done;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MSB-first bit reader. Requests and source
// words are pushed through the valid/stall port under random idling. A
// scoreboard carries its own window, byte counters and unary run, works out
// each expected result as a word is taken, and compares results in order.
// ----------------------------------------------------------------------------
module tb_top;
  import mbr_pkg::*;

  class bitread_checker;
    logic [WordW-1:0] length;
    logic [WordW-1:0] fetched;
    logic [WordW-1:0] unary_run;
    logic [WinW-1:0]  win;
    int unsigned      held;
    result_t          expected_q[$];
    int unsigned      errors;

    function new();
      length = '0;
      errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      win       = '0;
      held      = 0;
      fetched   = '0;
      unary_run = '0;
    endfunction

    function bit used_up();
      return fetched >= length;
    endfunction

    function void drop(int unsigned k);
      win  = (k >= 64) ? '0 : win << k;
      held = (k >= held) ? 0 : held - k;
    endfunction

    function logic [WordW-1:0] sat_add(logic [WordW-1:0] a, int unsigned b);
      logic [WordW:0] s;
      s = {1'b0, a} + b;
      return s[WordW] ? '1 : s[WordW-1:0];
    endfunction

    function void set_length(logic [WordW-1:0] v);
      length = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Advance the stream state by one taken word and queue its result.
    function void take_item(logic [2:0] fn, logic [CountW-1:0] cnt, logic [WordW-1:0] word);
      result_t          want;
      int unsigned      c;
      int unsigned      n;
      int unsigned      ones;
      logic [WordW-1:0] rem;
      logic [WordW-1:0] w;
      int unsigned      held_bytes;
      want = '0;
      want.status = ST_DONE;
      case (fn)
        OP_SUPPLY: begin
          if (held > 32 || used_up()) begin
            want.status = ST_REFUSED;
          end else begin
            rem = length - fetched;
            n = (rem >= 4) ? 4 : int'(rem);
            w = (word >> ((4 - n) * 8)) << ((4 - n) * 8);
            win = win | ({32'd0, w} << (32 - held));
            held = held + n * 8;
            fetched = fetched + n;
          end
        end
        OP_READ: begin
          c = (cnt > 32) ? 32 : cnt;
          if (c != 0) begin
            if (held >= c) begin
              want.value = WordW'(win >> (64 - c));
              drop(c);
            end else if (used_up()) begin
              // pad with zeros past the end and empty the window
              want.value = WordW'(win >> (64 - c));
              win = '0;
              held = 0;
            end else begin
              want.status = ST_NEED_DATA;
            end
          end
        end
        OP_UNARY: begin
          ones = 0;
          while (ones < held && win[63 - ones]) ones++;
          if (ones < held) begin
            want.value = sat_add(unary_run, ones);
            unary_run = '0;
            drop(ones + 1);
          end else begin
            // run cut off: keep the partial count
            unary_run = sat_add(unary_run, ones);
            drop(ones);
            if (used_up()) begin
              want.value = unary_run;
              unary_run = '0;
            end else begin
              want.status = ST_NEED_DATA;
            end
          end
        end
        OP_ALIGN: drop(held & 7);
        OP_RESTART: clear_stream();
        default: ;
      endcase
      held_bytes = held >> 3;
      want.held = HeldW'(held);
      want.consumed = (fetched >= held_bytes) ? fetched - held_bytes : '0;
      want.done = used_up();
      expected_q.push_back(want);
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: value %h status %0d", got.value, got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %h, got %h", want.value, got.value);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.held !== want.held) begin
        $error("bits_held: expected %0d, got %0d", want.held, got.held);
        errors++;
      end
      if (got.consumed !== want.consumed) begin
        $error("bytes_consumed: expected %0d, got %0d", want.consumed, got.consumed);
        errors++;
      end
      if (got.done !== want.done) begin
        $error("source_done: expected %0b, got %0b", want.done, got.done);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni         = 1'b0;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic [WordW-1:0]   cfg_wdata_i    = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [2:0]         func_i         = '0;
  logic [CountW-1:0]  bit_count_i    = '0;
  logic [WordW-1:0]   source_word_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [WordW-1:0]   value_o;
  logic [1:0]         status_o;
  logic [HeldW-1:0]   bits_held_o;
  logic [WordW-1:0]   bytes_consumed_o;
  logic               source_done_o;

  bitread_checker sb = new();
  bit             calm  = 1'b0;
  bit             quiet = 1'b0;
  int unsigned    stall_left = 0;

  msb_first_bit_reader uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .bit_count_i      (bit_count_i),
    .source_word_i    (source_word_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .value_o          (value_o),
    .status_o         (status_o),
    .bits_held_o      (bits_held_o),
    .bytes_consumed_o (bytes_consumed_o),
    .source_done_o    (source_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Result side: check taken results, stall in random bursts.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.value    = value_o;
        got.status   = status_e'(status_o);
        got.held     = bits_held_o;
        got.consumed = bytes_consumed_o;
        got.done     = source_done_o;
        sb.match_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(1, 19);
        out_stall_i <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic [2:0] fn, input logic [CountW-1:0] cnt,
                           input logic [WordW-1:0] word);
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    bit_count_i   <= cnt;
    source_word_i <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.take_item(fn, cnt, word);
    if (!calm && !quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // Hold off until every result is back, then let the pipe drain.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [WordW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_length(v);
  endtask

  task automatic send_stream_item();
    int unsigned      r;
    logic [WordW-1:0] w;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: w = '1;
      1: w = ~(32'hFFFF_FFFF >> $urandom_range(0, 32));
      default: w = $urandom();
    endcase
    if (r < 40 && sb.held <= 32 && !sb.used_up()) begin
      push_item(OP_SUPPLY, CountW'($urandom()), w);
    end else if (r < 70) begin
      push_item(OP_READ, CountW'($urandom_range(1, 32)), w);
    end else if (r < 84) begin
      push_item(OP_UNARY, CountW'($urandom()), w);
    end else if (r < 89) begin
      push_item(OP_ALIGN, CountW'($urandom()), w);
    end else if (r < 91) begin
      push_item(OP_RESTART, CountW'($urandom()), w);
    end else begin
      // noise: any code, any count, including refused and ignored cases
      push_item(3'($urandom()), CountW'($urandom()), w);
    end
  endtask

  initial begin
    int               ph;
    logic [WordW-1:0] len;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty source straight out of reset.
    push_item(OP_SUPPLY, 6'd0, 32'h1234_5678);
    push_item(OP_READ, 6'd7, '0);
    push_item(OP_UNARY, 6'd0, '0);
    push_item(OP_NOP, 6'd63, '1);
    wait_idle();

    // Nine-byte stream: need data, cut-off run, padded tail, a refusal.
    write_length(32'd9);
    push_item(OP_RESTART, 6'd0, '0);
    push_item(OP_READ, 6'd4, '0);
    push_item(OP_UNARY, 6'd0, '0);
    push_item(OP_SUPPLY, 6'd0, 32'hFFFF_FFFF);
    push_item(OP_UNARY, 6'd0, '0);
    push_item(OP_SUPPLY, 6'd0, 32'hFFF0_A5C3);
    push_item(OP_SUPPLY, 6'd0, 32'h8000_00FF);
    push_item(OP_SUPPLY, 6'd0, 32'hDEAD_BEEF);
    push_item(OP_UNARY, 6'd0, '0);
    push_item(OP_READ, 6'd0, '0);
    push_item(OP_ALIGN, 6'd0, '0);
    push_item(OP_READ, 6'd63, '0);
    push_item(OP_READ, 6'd1, '0);
    push_item(OP_RESTART, 6'd0, '0);
    push_item(OP_READ, 6'd32, '0);

    for (ph = 0; ph < 12; ph++) begin
      wait_idle();
      quiet = ($urandom_range(0, 3) == 0);
      calm  = (ph == 11);
      case (ph)
        0:       len = '1;
        1:       len = $urandom_range(1, 8);
        2:       len = $urandom_range(9, 60);
        3:       len = '0;
        4:       len = $urandom_range(20, 200);
        5:       len = (sb.fetched == 0) ? '0 : $urandom_range(0, sb.fetched - 1);
        6:       len = $urandom();
        default: len = $urandom_range(1, 120);
      endcase
      write_length(len);
      // shrink the length under a live stream on one phase
      if (ph != 5) push_item(OP_RESTART, CountW'($urandom()), $urandom());
      repeat (75) send_stream_item();
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/mbr_pkg.sv
design/mbr_front.sv
design/mbr_queue.sv
design/mbr_back.sv
design/msb_first_bit_reader.sv
tb/tb_top.sv
